FILE: hdl/aba_pkg.sv
// ----------------------------------------------------------------------------
// aba_pkg
// Shared types and constants for the ASID bitmap allocator.
// ----------------------------------------------------------------------------
package aba_pkg;

	localparam int NUM_IDS_DEF = 256;
	localparam int WORD_BITS   = 64;
	localparam int BIT_W       = $clog2(WORD_BITS);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] free_id;
	} req_t;

	typedef struct packed {
		logic [7:0] granted_id;
		logic       granted;
	} rsp_t;

endpackage

FILE: hdl/aba_map_ram.sv
// ----------------------------------------------------------------------------
// aba_map_ram
// Word-wide bitmap storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aba_map_ram #(
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [aba_pkg::WORD_BITS-1:0]   wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic [aba_pkg::WORD_BITS-1:0]   rdata
);

	logic [aba_pkg::WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/aba_word_scan.sv
// ----------------------------------------------------------------------------
// aba_word_scan
// Masks one bitmap word for the current visit and finds its lowest free bit.
// ----------------------------------------------------------------------------
module aba_word_scan #(
	parameter int NUM_IDS = aba_pkg::NUM_IDS_DEF,
	parameter int AW      = 2
) (
	input  logic [aba_pkg::WORD_BITS-1:0] data,
	input  logic [AW-1:0]                 word,
	input  logic [aba_pkg::BIT_W-1:0]     off,
	input  logic                          first,
	input  logic                          last,
	output logic                          found,
	output logic [aba_pkg::BIT_W-1:0]     bit_idx
);

	logic [aba_pkg::WORD_BITS-1:0] cand;

	// first visit covers bits at or above the start offset, the wrap-around
	// visit of the same word covers the bits below it
	always_comb begin
		for (int b = 0; b < aba_pkg::WORD_BITS; b++) begin
			cand[b] = !data[b]
				&& (!first || (aba_pkg::BIT_W'(b) >= off))
				&& (!last  || (aba_pkg::BIT_W'(b) <  off))
				&& (32'({word, aba_pkg::BIT_W'(b)}) < NUM_IDS);
		end
	end

	always_comb begin
		found   = 1'b0;
		bit_idx = '0;
		for (int b = aba_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				found   = 1'b1;
				bit_idx = aba_pkg::BIT_W'(b);
			end
		end
	end

endmodule

FILE: hdl/asid_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// asid_bitmap_allocator
// Next-fit ASID allocator over a word-wide bitmap, one word checked per cycle.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------
//  request  | start, busy          | req  (kind, free_id)
//  result   | done (1-cycle pulse) | rsp  (granted_id, granted)
//
//  Allocate: busy while words (W = ceil(NUM_IDS/64) of them) go, one word
//  through the shared scan unit per cycle; the result pulses right after.
//  Free: busy for one read-modify-write; an ignored free costs nothing.
//  After reset a clearing pass writes all W words with busy high.
//  The result channel cannot stall; done is never held.
// ----------------------------------------------------------------------------
module asid_bitmap_allocator #(
	parameter int NUM_IDS = aba_pkg::NUM_IDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  aba_pkg::req_t req,
	output logic          done,
	output aba_pkg::rsp_t rsp
);

	localparam int W   = (NUM_IDS + aba_pkg::WORD_BITS - 1) / aba_pkg::WORD_BITS;
	localparam int AW  = (W > 1) ? $clog2(W) : 1;
	localparam int IXW = AW + aba_pkg::BIT_W;
	localparam int VW  = $clog2(W + 1);
	localparam int BW  = aba_pkg::BIT_W;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_FREE  = 4'b1000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   word_q;
	logic [VW-1:0]   visit_q;
	logic [IXW-1:0]  ptr_q;
	logic [AW-1:0]   fword_q;
	logic [BW-1:0]   fbit_q;
	logic            done_q;
	aba_pkg::rsp_t   rsp_q;

	logic                          accept;
	logic [IXW-1:0]                fid_ix;
	logic                          fid_ok;
	logic [AW-1:0]                 word_nxt;
	logic                          first;
	logic                          last;
	logic                          found;
	logic [BW-1:0]                 bit_idx;
	logic [IXW-1:0]                hit_ix;
	logic [IXW:0]                  hit_inc;
	logic                          we;
	logic [AW-1:0]                 waddr;
	logic [aba_pkg::WORD_BITS-1:0] wdata;
	logic                          re;
	logic [AW-1:0]                 raddr;
	logic [aba_pkg::WORD_BITS-1:0] rdata;

	assign accept   = start && (state_q == ST_IDLE);
	assign fid_ix   = IXW'(req.free_id);
	assign fid_ok   = (req.free_id != 8'd0) && (32'(req.free_id) < NUM_IDS);
	assign word_nxt = (word_q == AW'(W - 1)) ? '0 : word_q + 1'b1;
	assign first    = (visit_q == '0);
	assign last     = (visit_q == VW'(W));
	assign hit_ix   = {word_q, bit_idx};
	assign hit_inc  = {1'b0, hit_ix} + 1'b1;

	aba_word_scan #(
		.NUM_IDS (NUM_IDS),
		.AW      (AW)
	) u_scan (
		.data    (rdata),
		.word    (word_q),
		.off     (ptr_q[BW-1:0]),
		.first   (first),
		.last    (last),
		.found   (found),
		.bit_idx (bit_idx)
	);

	aba_map_ram #(
		.DEPTH (W),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = word_q;
		wdata = rdata;
		re    = 1'b0;
		raddr = word_nxt;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = (word_q == '0) ? aba_pkg::WORD_BITS'(1) : '0;
			end
			ST_IDLE: begin
				if (accept) begin
					re    = (req.kind == aba_pkg::KIND_ALLOC) || fid_ok;
					raddr = (req.kind == aba_pkg::KIND_ALLOC) ? ptr_q[IXW-1:BW]
					                                          : fid_ix[IXW-1:BW];
				end
			end
			ST_SCAN: begin
				if (found) begin
					we    = 1'b1;
					wdata = rdata | (aba_pkg::WORD_BITS'(1) << bit_idx);
				end else if (!last) begin
					re = 1'b1;
				end
			end
			ST_FREE: begin
				we    = 1'b1;
				waddr = fword_q;
				wdata = rdata & ~(aba_pkg::WORD_BITS'(1) << fbit_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			word_q  <= '0;
			visit_q <= '0;
			ptr_q   <= IXW'(1 % NUM_IDS);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					word_q <= word_nxt;
					if (word_q == AW'(W - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.kind == aba_pkg::KIND_ALLOC) begin
							word_q  <= ptr_q[IXW-1:BW];
							visit_q <= '0;
							state_q <= ST_SCAN;
						end else if (fid_ok) begin
							state_q <= ST_FREE;
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						ptr_q   <= (hit_inc == (IXW + 1)'(NUM_IDS)) ? '0 : hit_inc[IXW-1:0];
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						word_q  <= word_nxt;
						visit_q <= visit_q + 1'b1;
					end
				end
				ST_FREE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result and free target registers carry payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			fword_q <= fid_ix[IXW-1:BW];
			fbit_q  <= fid_ix[BW-1:0];
		end
		if (state_q == ST_SCAN) begin
			rsp_q.granted    <= found;
			rsp_q.granted_id <= found ? 8'(hit_ix) : 8'd0;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hdl/aba_checker.sv
// ----------------------------------------------------------------------------
// aba_checker
// Port-level checks on the allocator's request and result timing.
// ----------------------------------------------------------------------------
module aba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input aba_pkg::req_t req,
	input logic          done,
	input aba_pkg::rsp_t rsp
);

	// an accepted allocation always makes the block go busy
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.kind == aba_pkg::KIND_ALLOC) |=> busy)
		else $error("allocate accepted without going busy");

	// frees never produce a result
	a_free_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.kind == aba_pkg::KIND_FREE) |=> !done)
		else $error("result after a free");

	// the result pulse lands once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.granted |-> (rsp.granted_id == 8'd0))
		else $error("failed allocation carries a nonzero id");

endmodule

bind asid_bitmap_allocator aba_checker u_aba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

FILE: test/tb_asid_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// tb_asid_bitmap_allocator
// Self-checking bench for the next-fit ASID allocator. A bit-level predictor
// tracks the in-use map and the rotating search pointer. Each accepted
// allocate queues the expected grant, and every done pulse is checked against
// the oldest queued grant. Stimulus runs through first grants, pool
// exhaustion with pointer wrap, random churn and a full drain, with random
// idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_asid_bitmap_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_IDS        = aba_pkg::NUM_IDS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	aba_pkg::req_t  req;
	logic           done;
	aba_pkg::rsp_t  rsp;

	// predictor state
	logic [NUM_IDS-1:0] id_in_use;
	int                 scan_origin;
	aba_pkg::rsp_t      expected_grants[$];
	int                 mismatch_count;
	bit                 gaps_on;

	asid_bitmap_allocator #(
		.NUM_IDS(NUM_IDS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// next-fit scan over the map; frees give no result
	function automatic void model_request(input aba_pkg::req_t r);
		aba_pkg::rsp_t grant;
		int            id;
		if (r.kind == aba_pkg::KIND_FREE) begin
			if (r.free_id != 8'd0 && int'(r.free_id) < NUM_IDS)
				id_in_use[r.free_id] = 1'b0;
			return;
		end
		grant = '0;
		for (int i = 0; i < NUM_IDS; i++) begin
			id = (scan_origin + i) % NUM_IDS;
			if (grant.granted == 1'b0 && id != 0 && !id_in_use[id]) begin
				id_in_use[id]    = 1'b1;
				scan_origin      = (id + 1) % NUM_IDS;
				grant.granted_id = id[7:0];
				grant.granted    = 1'b1;
			end
		end
		expected_grants.push_back(grant);
	endfunction

	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// prefers an identifier that is currently held
	function automatic logic [7:0] pick_busy_id();
		int id;
		for (int n = 0; n < 64; n++) begin
			id = $urandom_range(1, NUM_IDS - 1);
			if (id_in_use[id])
				return id[7:0];
		end
		return id[7:0];
	endfunction

	task automatic send_request(input logic kind, input logic [7:0] id);
		aba_pkg::req_t r;
		int            gap;
		r.kind    = kind;
		r.free_id = id;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		model_request(r);
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			req   <= aba_pkg::req_t'(9'($urandom_range(0, 511)));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic allocate();
		send_request(aba_pkg::KIND_ALLOC, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_first_grants();
		gaps_on = 1'b0;
		send_request(aba_pkg::KIND_ALLOC, 8'h00);
		send_request(aba_pkg::KIND_ALLOC, 8'hFF);
		allocate();
		send_request(aba_pkg::KIND_FREE, 8'd2);
		allocate();                                  // next fit: 4, not 2
		send_request(aba_pkg::KIND_FREE, 8'd0);      // reserved, ignored
		send_request(aba_pkg::KIND_FREE, 8'd200);    // already clear
		send_request(aba_pkg::KIND_FREE, 8'd255);
		send_request(aba_pkg::KIND_FREE, 8'hAA);
		send_request(aba_pkg::KIND_FREE, 8'h55);
		allocate();
		send_request(aba_pkg::KIND_FREE, 8'd1);
		send_request(aba_pkg::KIND_FREE, 8'd3);
		gaps_on = 1'b1;
		allocate();
		allocate();
	endtask

	// fill to exhaustion, pointer wraps through zero on the way
	task automatic test_pool_exhaustion();
		logic [7:0] id;
		gaps_on = 1'b1;
		while (!(&id_in_use)) begin
			if ($urandom_range(0, 99) < 5)
				send_request(aba_pkg::KIND_FREE, pick_busy_id());
			else
				allocate();
		end
		repeat (3) allocate();
		send_request(aba_pkg::KIND_FREE, 8'd0);
		allocate();
		id = 8'($urandom_range(1, NUM_IDS - 1));
		send_request(aba_pkg::KIND_FREE, id);
		allocate();
		allocate();
	endtask

	task automatic test_random_churn();
		int alloc_pct;
		gaps_on = 1'b1;
		for (int phase = 0; phase < 6; phase++) begin
			alloc_pct = $urandom_range(20, 80);
			gaps_on   = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 99) < alloc_pct)
					allocate();
				else if ($urandom_range(0, 9) == 0)
					send_request(aba_pkg::KIND_FREE, 8'($urandom_range(0, 255)));
				else
					send_request(aba_pkg::KIND_FREE, pick_busy_id());
			end
		end
	endtask

	task automatic test_drain();
		int order[$];
		gaps_on = 1'b1;
		for (int id = 1; id < NUM_IDS; id++)
			if (id_in_use[id])
				order.push_back(id);
		order.shuffle();
		foreach (order[k])
			send_request(aba_pkg::KIND_FREE, 8'(order[k]));
		repeat (6) allocate();
	endtask

	// result check
	always @(posedge clk) begin
		aba_pkg::rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_grants.size() == 0) begin
				$display("%0t: unexpected result, expected none, got id %0d granted %0b",
					$time, rsp.granted_id, rsp.granted);
				mismatch_count++;
			end else begin
				want = expected_grants.pop_front();
				if (rsp.granted_id !== want.granted_id) begin
					$display("%0t: granted_id expected %0d, got %0d",
						$time, want.granted_id, rsp.granted_id);
					mismatch_count++;
				end
				if (rsp.granted !== want.granted) begin
					$display("%0t: granted expected %0b, got %0b",
						$time, want.granted, rsp.granted);
					mismatch_count++;
				end
			end
		end
	end

	// no progress for too long ends the run
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stalled = 0;
			else
				stalled++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		start          <= 1'b0;
		req            <= '0;
		id_in_use       = '0;
		id_in_use[0]    = 1'b1;
		scan_origin     = 1;
		mismatch_count  = 0;
		gaps_on         = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_grants();
		test_pool_exhaustion();
		test_random_churn();
		test_drain();

		start <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_grants.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
